[sv/tlmu_pkg.sv]
// shared types and constants for the two-list membership update block
package tlmu_pkg;

  localparam int NUM_ENTRIES = 1024;
  localparam int IDX_W       = 11;
  localparam int VAL_W       = 32;
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);
  localparam int LINK_W      = $clog2(NUM_ENTRIES + 1);

  localparam logic signed [VAL_W-1:0] MARKER_RESET = -32'sd999;

  typedef enum logic [1:0] {
    MOVE_NONE       = 2'd0,
    MOVE_TO_LIVE    = 2'd1,
    MOVE_TO_DELETED = 2'd2
  } move_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_NBR,
    ST_HEAD
  } state_t;

  typedef struct packed {
    logic        [IDX_W-1:0] entry_index;
    logic signed [VAL_W-1:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] prior_value;
    move_t                   move_taken;
    logic        [IDX_W-1:0] deleted_head_out;
    logic        [IDX_W-1:0] live_head_out;
  } out_word_t;

endpackage

[sv/two_list_membership_update_top.sv]
// two-list membership update: value table with deleted and live doubly linked lists
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-----------------------------
//  item      | in        | item_valid / item_stall  | entry_index, write_value
//  result    | out       | result_valid / result_stall | prior_value, move_taken, heads
//  cfg       | in        | cfg_we                   | cfg_data (deleted marker)
//
// an item that moves lists goes through accept and memory read, evaluate and write the
// entry's own links, write the two neighbor links, write the back link of the old target head
// an item with no list move skips the neighbor step
// the rate is set by the single write port of the prev and next link memories
// after reset and after every marker write a clear pass writes all NUM_ENTRIES entries
// (1024) while item_stall is high
// a result waiting under result_stall holds the block in its last step, the next
// word is accepted in the cycle after the result register is loaded
module two_list_membership_update_top import tlmu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic signed [VAL_W-1:0] cfg_data,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  in_word_t                item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output out_word_t               result
);

  logic signed [VAL_W-1:0] value_mem [NUM_ENTRIES];
  logic        [LINK_W-1:0] prev_mem [NUM_ENTRIES];
  logic        [LINK_W-1:0] next_mem [NUM_ENTRIES];

  state_t state, state_next;

  logic signed [VAL_W-1:0]  marker;
  logic        [ADDR_W-1:0] clr_addr;
  logic        [LINK_W-1:0] deleted_head, live_head;

  logic        [LINK_W-1:0] p_link;
  logic                     in_range;
  logic signed [VAL_W-1:0]  new_val;
  logic signed [VAL_W-1:0]  old_val;
  move_t                    move;
  logic        [LINK_W-1:0] pv, nx, ht;

  logic signed [VAL_W-1:0]  val_q;
  logic        [LINK_W-1:0] prv_q, nxt_q;

  logic                     item_take;
  logic        [ADDR_W-1:0] rd_addr;
  logic        [ADDR_W-1:0] p_addr;
  logic                     was_del, is_del;
  move_t                    move_next;
  logic        [LINK_W-1:0] ht_sel;
  logic                     out_free, result_load;

  logic                     val_we, prv_we, nxt_we;
  logic        [ADDR_W-1:0] val_wa, prv_wa, nxt_wa;
  logic signed [VAL_W-1:0]  val_wd;
  logic        [LINK_W-1:0] prv_wd, nxt_wd;

  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign rd_addr    = ADDR_W'(item.entry_index - IDX_W'(1));
  assign p_addr     = ADDR_W'(p_link - LINK_W'(1));
  assign out_free   = !result_valid || !result_stall;

  assign was_del = (val_q == marker);
  assign is_del  = (new_val == marker);

  always_comb begin
    move_next = MOVE_NONE;
    if (in_range && was_del && !is_del) begin
      move_next = MOVE_TO_LIVE;
    end else if (in_range && !was_del && is_del) begin
      move_next = MOVE_TO_DELETED;
    end
  end

  assign ht_sel = (move_next == MOVE_TO_LIVE) ? live_head : deleted_head;

  // next state and memory write control
  always_comb begin
    state_next  = state;
    result_load = 1'b0;
    val_we = 1'b0;
    val_wa = p_addr;
    val_wd = new_val;
    prv_we = 1'b0;
    prv_wa = p_addr;
    prv_wd = '0;
    nxt_we = 1'b0;
    nxt_wa = p_addr;
    nxt_wd = '0;
    case (state)
      ST_CLEAR: begin
        val_we = 1'b1;
        val_wa = clr_addr;
        val_wd = marker;
        prv_we = 1'b1;
        prv_wa = clr_addr;
        prv_wd = LINK_W'(clr_addr);
        nxt_we = 1'b1;
        nxt_wa = clr_addr;
        nxt_wd = (clr_addr == ADDR_W'(NUM_ENTRIES - 1)) ? '0
                                                        : LINK_W'(clr_addr) + LINK_W'(2);
        if (clr_addr == ADDR_W'(NUM_ENTRIES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_take) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        val_we = in_range;
        // entry goes to the head of the other list
        if (move_next != MOVE_NONE) begin
          prv_we = 1'b1;
          prv_wd = '0;
          nxt_we = 1'b1;
          nxt_wd = ht_sel;
          state_next = ST_NBR;
        end else begin
          state_next = ST_HEAD;
        end
      end
      ST_NBR: begin
        // unlink from the old list
        nxt_we = (pv != '0);
        nxt_wa = ADDR_W'(pv - LINK_W'(1));
        nxt_wd = nx;
        prv_we = (nx != '0);
        prv_wa = ADDR_W'(nx - LINK_W'(1));
        prv_wd = pv;
        state_next = ST_HEAD;
      end
      ST_HEAD: begin
        prv_we = (move != MOVE_NONE) && (ht != '0);
        prv_wa = ADDR_W'(ht - LINK_W'(1));
        prv_wd = p_link;
        if (out_free) begin
          result_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[val_wa] <= val_wd;
    end
    if (item_take) begin
      val_q <= value_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (prv_we) begin
      prev_mem[prv_wa] <= prv_wd;
    end
    if (item_take) begin
      prv_q <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      next_mem[nxt_wa] <= nxt_wd;
    end
    if (item_take) begin
      nxt_q <= next_mem[rd_addr];
    end
  end

  // control state, marker and list heads
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      marker       <= MARKER_RESET;
      deleted_head <= LINK_W'(1);
      live_head    <= '0;
    end else if (cfg_we) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      marker       <= cfg_data;
      deleted_head <= LINK_W'(1);
      live_head    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == ST_EVAL) begin
        if (move_next == MOVE_TO_LIVE) begin
          live_head <= p_link;
          if (deleted_head == p_link) begin
            deleted_head <= nxt_q;
          end
        end else if (move_next == MOVE_TO_DELETED) begin
          deleted_head <= p_link;
          if (live_head == p_link) begin
            live_head <= nxt_q;
          end
        end
      end
    end
  end

  // item context
  always_ff @(posedge clk) begin
    if (item_take) begin
      p_link   <= LINK_W'(item.entry_index);
      in_range <= (item.entry_index != '0) && (32'(item.entry_index) <= NUM_ENTRIES);
      new_val  <= item.write_value;
    end
    if (state == ST_EVAL) begin
      old_val <= in_range ? val_q : '0;
      move    <= move_next;
      pv      <= prv_q;
      nx      <= nxt_q;
      ht      <= ht_sel;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.prior_value      <= old_val;
      result.move_taken       <= move;
      result.deleted_head_out <= IDX_W'(deleted_head);
      result.live_head_out    <= IDX_W'(live_head);
    end
  end

  a_heads_disjoint: assert property (@(posedge clk) disable iff (rst)
    !(deleted_head != '0 && deleted_head == live_head))
    else $error("both lists share a head entry");

  a_heads_range: assert property (@(posedge clk) disable iff (rst)
    (32'(deleted_head) <= NUM_ENTRIES) && (32'(live_head) <= NUM_ENTRIES))
    else $error("list head beyond table");

  a_result_from_head: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_HEAD)
    else $error("result loaded outside final step");

  a_nbr_has_move: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NBR) |-> (move != MOVE_NONE) && in_range)
    else $error("neighbor link step without a list move");

endmodule
